FILE: rtl/ttacc_pkg.sv
// Shared types, codes and saturation helpers of the triangle tangent accumulator.
package ttacc_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int INDEX_W       = 10;
    localparam int EXT_W         = 17;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 65;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] STAT_LOADED = 2'd0;
    localparam logic [1:0] STAT_TRI_OK = 2'd1;
    localparam logic [1:0] STAT_DEGEN  = 2'd2;
    localparam logic [1:0] STAT_READ   = 2'd3;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]                command;
        logic [INDEX_W-1:0]        index_a;
        logic [INDEX_W-1:0]        index_b;
        logic [INDEX_W-1:0]        index_c;
        logic signed [DATA_W-1:0]  pos_x;
        logic signed [DATA_W-1:0]  pos_y;
        logic signed [DATA_W-1:0]  pos_z;
        logic signed [DATA_W-1:0]  tex_u;
        logic signed [DATA_W-1:0]  tex_v;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [INDEX_W-1:0]        vertex_index;
        logic signed [DATA_W-1:0]  tangent_x;
        logic signed [DATA_W-1:0]  tangent_y;
        logic signed [DATA_W-1:0]  tangent_z;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] tu;
        logic signed [DATA_W-1:0] tv;
    } vtx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
        logic signed [DATA_W-1:0] tz;
    } tan_t;

    typedef enum logic [3:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_DISPATCH,
        CTL_POS_B,
        CTL_POS_C,
        CTL_POS_D,
        CTL_MUL,
        CTL_CHECK,
        CTL_DIV_START,
        CTL_DIV_WAIT,
        CTL_ACC_RD,
        CTL_ACC_WR,
        CTL_TAN_RD,
        CTL_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_ITER,
        DIV_DONE
    } div_state_t;

    // Clamp a 33-bit sum or difference into 32 bits.
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
            return v[DATA_W] ? DATA_MIN : DATA_MAX;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat33(d);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat33(s);
    endfunction

endpackage

FILE: rtl/ttacc_mult.sv
// Shared signed 32x32 multiplier with a registered product.
module ttacc_mult
(
    input  logic                                clk,
    input  logic signed [ttacc_pkg::DATA_W-1:0] op_a,
    input  logic signed [ttacc_pkg::DATA_W-1:0] op_b,
    output logic signed [ttacc_pkg::PROD_W-1:0] prod
);
    import ttacc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/ttacc_div.sv
// Iterative restoring divider: saturated num * 2^16 / den, one quotient bit per cycle.
module ttacc_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ttacc_pkg::SUM_W-1:0]  num,
    input  logic signed [ttacc_pkg::SUM_W-1:0]  den,
    output logic                                done,
    output logic signed [ttacc_pkg::DATA_W-1:0] quot
);
    import ttacc_pkg::*;

    div_state_t state_reg, state_next;

    logic [PROD_W-1:0] un_reg, ud_reg, rem_reg;
    logic [DATA_W-1:0] lo_reg, q_reg;
    logic [4:0]        cnt_reg;
    logic              neg_reg, ovf_reg;

    logic [SUM_W-1:0]  num_abs, den_abs;
    logic [SUM_W-1:0]  shifted, diff;
    logic              ge;

    assign num_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    assign den_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    assign shifted = {rem_reg, lo_reg[DATA_W-1]};
    assign ge      = shifted >= {1'b0, ud_reg};
    assign diff    = shifted - {1'b0, ud_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_LOAD;
            DIV_LOAD: state_next = DIV_ITER;
            DIV_ITER: if (cnt_reg == 5'd31) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DIV_IDLE:
            begin
                un_reg  <= num_abs[PROD_W-1:0];
                ud_reg  <= den_abs[PROD_W-1:0];
                neg_reg <= num[SUM_W-1] ^ den[SUM_W-1];
            end
            DIV_LOAD:
            begin
                // quotient of 2^32 or more saturates
                ovf_reg <= (un_reg >> 16) >= ud_reg;
                rem_reg <= un_reg >> 16;
                lo_reg  <= {un_reg[15:0], 16'd0};
                cnt_reg <= '0;
            end
            DIV_ITER:
            begin
                rem_reg <= ge ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
                lo_reg  <= lo_reg << 1;
                q_reg   <= {q_reg[DATA_W-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (ovf_reg)
            quot = neg_reg ? DATA_MIN : DATA_MAX;
        else if (neg_reg)
            quot = q_reg[DATA_W-1] ? DATA_MIN : -$signed(q_reg);
        else
            quot = q_reg[DATA_W-1] ? DATA_MAX : $signed(q_reg);
    end

    assign done = (state_reg == DIV_DONE);

endmodule

FILE: rtl/triangle_tangent_accumulator_core.sv
// Top level of the triangle tangent accumulator: sequencer, vertex and tangent memories.
//
// Usage: items arrive on req (req_valid/req_ready), results leave on rsp
// (rsp_valid/rsp_ready); both are plain valid/ready channels with packed
// struct payloads. A load item writes a vertex and clears its tangent sum,
// a triangle item adds its Q16.16 tangent to all three corners, a read item
// returns a vertex's tangent sum. Command 3 is dropped without a result.
//
// One item is in work at a time; req_ready is high only in idle, which starts as the result is registered.
// A triangle item reads its three vertices, forms det and the three numerators
// on the shared multiplier, then runs three divisions on the shared divider
// (one quotient bit a cycle) and a read-modify-write of each of the three
// corners; one with an index out of range or a zero det skips the rest.
//
// After reset the tangent memory is swept to zero, one entry a cycle, over
// all VERTEX_DEPTH entries; req_ready stays low meanwhile. The result sits in
// an output register; when the receiver stalls the block finishes its item,
// waits with it until that register is free, and accepts no item meanwhile.
module triangle_tangent_accumulator_core
#(
    parameter int VERTEX_DEPTH = ttacc_pkg::DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ttacc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ttacc_pkg::rsp_t   rsp
);
    import ttacc_pkg::*;

    localparam int ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(VERTEX_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_DEPTH - 1);

    // Convert an item index to a memory address (zero-extend, then cut to ADDR_W).
    function automatic logic [ADDR_W-1:0] to_addr(input logic [INDEX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = {{(EXT_W-INDEX_W){1'b0}}, idx};
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic in_range(input logic [INDEX_W-1:0] idx);
        return {{(EXT_W-INDEX_W){1'b0}}, idx} < DEPTH_EXT;
    endfunction

    ctl_state_t state_reg, state_next;

    // memories
    vtx_t pos_mem [VERTEX_DEPTH];
    tan_t tan_mem [VERTEX_DEPTH];
    vtx_t pos_rd_reg;
    tan_t tan_rd_reg;

    logic              pos_we, pos_re, tan_we, tan_re;
    logic [ADDR_W-1:0] pos_waddr, pos_raddr, tan_waddr, tan_raddr;
    tan_t              tan_wdata;

    // item and working registers
    req_t              item_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [3:0]        step_reg;
    logic [1:0]        corner_reg;
    vtx_t              v0_reg;
    logic signed [DATA_W-1:0] e1x_reg, e1y_reg, e1z_reg, du1_reg, dv1_reg;
    logic signed [DATA_W-1:0] e2x_reg, e2y_reg, e2z_reg, du2_reg, dv2_reg;
    logic signed [PROD_W-1:0] part_reg;
    logic signed [SUM_W-1:0]  det_reg, numx_reg, numy_reg, numz_reg;
    tan_t              t_reg;
    tan_t              res_reg;
    logic [1:0]        status_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  prod_diff;
    logic              div_start, div_done;
    logic signed [SUM_W-1:0]  div_num;
    logic signed [DATA_W-1:0] div_quot;
    logic [ADDR_W-1:0] corner_addr;
    logic              tri_in_range;
    logic              out_free;

    ttacc_mult u_mult
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ttacc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign prod_diff    = SUM_W'(part_reg) - SUM_W'(prod);
    assign tri_in_range = in_range(item_reg.index_a) && in_range(item_reg.index_b)
                          && in_range(item_reg.index_c);
    assign out_free     = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_addr = to_addr(item_reg.index_a);
            2'd1:    corner_addr = to_addr(item_reg.index_b);
            default: corner_addr = to_addr(item_reg.index_c);
        endcase
    end

    always_comb
    begin
        unique case (corner_reg)
            2'd0:    div_num = numx_reg;
            2'd1:    div_num = numy_reg;
            default: div_num = numz_reg;
        endcase
    end

    // Operand pairs for det and the three numerators.
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin mul_a = du1_reg; mul_b = dv2_reg; end
            4'd1:    begin mul_a = du2_reg; mul_b = dv1_reg; end
            4'd2:    begin mul_a = dv2_reg; mul_b = e1x_reg; end
            4'd3:    begin mul_a = dv1_reg; mul_b = e2x_reg; end
            4'd4:    begin mul_a = dv2_reg; mul_b = e1y_reg; end
            4'd5:    begin mul_a = dv1_reg; mul_b = e2y_reg; end
            4'd6:    begin mul_a = dv2_reg; mul_b = e1z_reg; end
            4'd7:    begin mul_a = dv1_reg; mul_b = e2z_reg; end
            default: begin mul_a = du1_reg; mul_b = dv2_reg; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_CLEAR:
                if (clr_reg == LAST_ADDR) state_next = CTL_IDLE;
            CTL_IDLE:
                if (req_valid) state_next = CTL_DISPATCH;
            CTL_DISPATCH:
            begin
                unique case (item_reg.command)
                    CMD_LOAD: state_next = CTL_DONE;
                    CMD_READ: state_next = in_range(item_reg.index_a) ? CTL_TAN_RD : CTL_DONE;
                    CMD_TRI:  state_next = tri_in_range ? CTL_POS_B : CTL_DONE;
                    default:  state_next = CTL_IDLE;
                endcase
            end
            CTL_POS_B:     state_next = CTL_POS_C;
            CTL_POS_C:     state_next = CTL_POS_D;
            CTL_POS_D:     state_next = CTL_MUL;
            CTL_MUL:
                if (step_reg == 4'd8) state_next = CTL_CHECK;
            CTL_CHECK:
                state_next = (det_reg == '0) ? CTL_DONE : CTL_DIV_START;
            CTL_DIV_START: state_next = CTL_DIV_WAIT;
            CTL_DIV_WAIT:
                if (div_done) state_next = (corner_reg == 2'd2) ? CTL_ACC_RD : CTL_DIV_START;
            CTL_ACC_RD:    state_next = CTL_ACC_WR;
            CTL_ACC_WR:
                state_next = (corner_reg == 2'd2) ? CTL_DONE : CTL_ACC_RD;
            CTL_TAN_RD:    state_next = CTL_DONE;
            CTL_DONE:
                if (out_free) state_next = CTL_IDLE;
            default:       state_next = CTL_IDLE;
        endcase
    end

    // outputs of the sequencer: memory ports, unit starts, handshake
    always_comb
    begin
        req_ready = 1'b0;
        pos_we    = 1'b0;
        pos_waddr = to_addr(item_reg.index_a);
        pos_re    = 1'b0;
        pos_raddr = to_addr(item_reg.index_a);
        tan_we    = 1'b0;
        tan_waddr = corner_addr;
        tan_wdata = '0;
        tan_re    = 1'b0;
        tan_raddr = corner_addr;
        div_start = 1'b0;
        unique case (state_reg)
            CTL_CLEAR:
            begin
                tan_we    = 1'b1;
                tan_waddr = clr_reg;
            end
            CTL_IDLE:
                req_ready = 1'b1;
            CTL_DISPATCH:
            begin
                if (item_reg.command == CMD_LOAD && in_range(item_reg.index_a))
                begin
                    pos_we    = 1'b1;
                    tan_we    = 1'b1;
                    tan_waddr = to_addr(item_reg.index_a);
                end
                if (item_reg.command == CMD_READ)
                begin
                    tan_re    = 1'b1;
                    tan_raddr = to_addr(item_reg.index_a);
                end
                if (item_reg.command == CMD_TRI)
                    pos_re = 1'b1;
            end
            CTL_POS_B:
            begin
                pos_re    = 1'b1;
                pos_raddr = to_addr(item_reg.index_b);
            end
            CTL_POS_C:
            begin
                pos_re    = 1'b1;
                pos_raddr = to_addr(item_reg.index_c);
            end
            CTL_DIV_START:
                div_start = 1'b1;
            CTL_ACC_RD:
                tan_re = 1'b1;
            CTL_ACC_WR:
            begin
                tan_we       = 1'b1;
                tan_wdata.tx = sat_add(tan_rd_reg.tx, t_reg.tx);
                tan_wdata.ty = sat_add(tan_rd_reg.ty, t_reg.ty);
                tan_wdata.tz = sat_add(tan_rd_reg.tz, t_reg.tz);
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= '{px: item_reg.pos_x, py: item_reg.pos_y,
                                    pz: item_reg.pos_z, tu: item_reg.tex_u,
                                    tv: item_reg.tex_v};
        if (pos_re)
            pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tan_we)
            tan_mem[tan_waddr] <= tan_wdata;
        if (tan_re)
            tan_rd_reg <= tan_mem[tan_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CTL_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == CTL_DONE && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (req_valid)
                    item_reg <= req;
            end
            CTL_DISPATCH:
            begin
                res_reg <= '0;
                unique case (item_reg.command)
                    CMD_LOAD: status_reg <= STAT_LOADED;
                    CMD_READ: status_reg <= STAT_READ;
                    default:  status_reg <= STAT_DEGEN;
                endcase
            end
            CTL_POS_B:
                v0_reg <= pos_rd_reg;
            CTL_POS_C:
            begin
                e1x_reg  <= sat_sub(pos_rd_reg.px, v0_reg.px);
                e1y_reg  <= sat_sub(pos_rd_reg.py, v0_reg.py);
                e1z_reg  <= sat_sub(pos_rd_reg.pz, v0_reg.pz);
                du1_reg  <= sat_sub(pos_rd_reg.tu, v0_reg.tu);
                dv1_reg  <= sat_sub(pos_rd_reg.tv, v0_reg.tv);
            end
            CTL_POS_D:
            begin
                e2x_reg  <= sat_sub(pos_rd_reg.px, v0_reg.px);
                e2y_reg  <= sat_sub(pos_rd_reg.py, v0_reg.py);
                e2z_reg  <= sat_sub(pos_rd_reg.pz, v0_reg.pz);
                du2_reg  <= sat_sub(pos_rd_reg.tu, v0_reg.tu);
                dv2_reg  <= sat_sub(pos_rd_reg.tv, v0_reg.tv);
                step_reg <= '0;
            end
            CTL_MUL:
            begin
                // product of the previous step arrives now
                step_reg <= step_reg + 4'd1;
                unique case (step_reg)
                    4'd2:    det_reg  <= prod_diff;
                    4'd4:    numx_reg <= prod_diff;
                    4'd6:    numy_reg <= prod_diff;
                    4'd8:    numz_reg <= prod_diff;
                    default: part_reg <= prod;
                endcase
            end
            CTL_CHECK:
                corner_reg <= '0;
            CTL_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (corner_reg)
                        2'd0:    t_reg.tx <= div_quot;
                        2'd1:    t_reg.ty <= div_quot;
                        default: t_reg.tz <= div_quot;
                    endcase
                    corner_reg <= (corner_reg == 2'd2) ? 2'd0 : corner_reg + 2'd1;
                end
            end
            CTL_ACC_WR:
            begin
                corner_reg <= corner_reg + 2'd1;
                if (corner_reg == 2'd2)
                    status_reg <= STAT_TRI_OK;
            end
            CTL_TAN_RD:
                res_reg <= tan_rd_reg;
            CTL_DONE:
            begin
                if (out_free)
                begin
                    rsp_reg.status       <= status_reg;
                    rsp_reg.vertex_index <= item_reg.index_a;
                    rsp_reg.tangent_x    <= res_reg.tx;
                    rsp_reg.tangent_y    <= res_reg.ty;
                    rsp_reg.tangent_z    <= res_reg.tz;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: bench/tb_triangle_tangent_accumulator_core.sv
// Testbench of the triangle tangent accumulator core: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_triangle_tangent_accumulator_core;
    import ttacc_pkg::*;

    localparam int  DEPTH      = 1024;
    localparam int  N_RANDOM   = 1900;
    localparam int  TAIL_WAIT  = 300;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Tangent predictor: shadow copies of the vertex and tangent tables.
    class tangent_scoreboard;
        logic signed [31:0] px [DEPTH];
        logic signed [31:0] py [DEPTH];
        logic signed [31:0] pz [DEPTH];
        logic signed [31:0] tu [DEPTH];
        logic signed [31:0] tv [DEPTH];
        logic signed [31:0] tx [DEPTH];
        logic signed [31:0] ty [DEPTH];
        logic signed [31:0] tz [DEPTH];
        bit                 loaded [DEPTH];
        rsp_t               pending [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                px[i] = 0; py[i] = 0; pz[i] = 0; tu[i] = 0; tv[i] = 0;
                tx[i] = 0; ty[i] = 0; tz[i] = 0; loaded[i] = 0;
            end
            mismatches = 0;
        endfunction

        static function longint clamp32(longint v);
            if (v > S32_MAX) return S32_MAX;
            if (v < S32_MIN) return S32_MIN;
            return v;
        endfunction

        // num * 2^16 / den, truncated toward zero, saturated to 32 bits
        static function longint q16_quotient(longint num, longint den);
            bit          neg;
            logic [63:0] un, ud, q, r, frac, m;
            neg  = (num < 0) != (den < 0);
            un   = (num < 0) ? -num : num;
            ud   = (den < 0) ? -den : den;
            q    = un / ud;
            r    = un % ud;
            frac = 0;
            if (q >= 65536)
                m = 64'd1 << 40;
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    r    = r << 1;
                    frac = frac << 1;
                    if (r >= ud)
                    begin
                        r    = r - ud;
                        frac = frac | 1;
                    end
                end
                m = (q << 16) | frac;
            end
            if (neg) return (m >= 64'h8000_0000) ? S32_MIN : -longint'(m);
            return (m > 64'h7fff_ffff) ? S32_MAX : longint'(m);
        endfunction

        function void add_tangent(int i, longint dx, longint dy, longint dz);
            tx[i] = 32'(clamp32(longint'(tx[i]) + dx));
            ty[i] = 32'(clamp32(longint'(ty[i]) + dy));
            tz[i] = 32'(clamp32(longint'(tz[i]) + dz));
        endfunction

        // Note an accepted item and queue the result it must cause.
        function void note_item(req_t r);
            rsp_t   e;
            int     a, b, c;
            longint e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2, det;
            longint gx, gy, gz;
            a = r.index_a; b = r.index_b; c = r.index_c;
            e = '0;
            e.vertex_index = r.index_a;
            case (r.command)
                CMD_NONE: return;
                CMD_LOAD:
                begin
                    px[a] = r.pos_x; py[a] = r.pos_y; pz[a] = r.pos_z;
                    tu[a] = r.tex_u; tv[a] = r.tex_v;
                    tx[a] = 0; ty[a] = 0; tz[a] = 0; loaded[a] = 1;
                    e.status = STAT_LOADED;
                end
                CMD_READ:
                begin
                    e.status    = STAT_READ;
                    e.tangent_x = tx[a];
                    e.tangent_y = ty[a];
                    e.tangent_z = tz[a];
                end
                default:
                begin
                    e.status = STAT_DEGEN;
                    e1x = clamp32(longint'(px[b]) - px[a]);
                    e1y = clamp32(longint'(py[b]) - py[a]);
                    e1z = clamp32(longint'(pz[b]) - pz[a]);
                    e2x = clamp32(longint'(px[c]) - px[a]);
                    e2y = clamp32(longint'(py[c]) - py[a]);
                    e2z = clamp32(longint'(pz[c]) - pz[a]);
                    du1 = clamp32(longint'(tu[b]) - tu[a]);
                    dv1 = clamp32(longint'(tv[b]) - tv[a]);
                    du2 = clamp32(longint'(tu[c]) - tu[a]);
                    dv2 = clamp32(longint'(tv[c]) - tv[a]);
                    det = du1 * dv2 - du2 * dv1;
                    if (det != 0)
                    begin
                        gx = q16_quotient(dv2 * e1x - dv1 * e2x, det);
                        gy = q16_quotient(dv2 * e1y - dv1 * e2y, det);
                        gz = q16_quotient(dv2 * e1z - dv1 * e2z, det);
                        add_tangent(a, gx, gy, gz);
                        add_tangent(b, gx, gy, gz);
                        add_tangent(c, gx, gy, gz);
                        e.status = STAT_TRI_OK;
                    end
                end
            endcase
            pending.push_back(e);
        endfunction

        // Compare one result with the oldest expectation.
        function void check_result(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.vertex_index !== e.vertex_index ||
                got.tangent_x !== e.tangent_x || got.tangent_y !== e.tangent_y ||
                got.tangent_z !== e.tangent_z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    tangent_scoreboard sb;
    longint            cycle_count;
    bit                idle_free;      // suppress random idling on both sides
    bit                hold_off_req;   // ask the receiver for a long stall
    int                tri_pool [$];   // vertices known loaded, for triangles

    triangle_tangent_accumulator_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        rst_n       = 1'b0;
        idle_free   = 1'b0;
        hold_off_req = 1'b0;
        cycle_count = 0;
        sb          = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: end the run at a generous limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                rsp_ready <= 1'b0;
                repeat (1500) @(posedge clk);
                hold_off_req = 1'b0;
            end
            rsp_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 21);
        end
    end

    // Check each accepted result at the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    // Offer one item and hold it until accepted; idle at random beforehand.
    // Valid stays high after acceptance until the next item or an idle cycle.
    task automatic send_item(req_t r);
        if (!idle_free)
            while ($urandom_range(99) < 21)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_item(r);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return 0;
            3: return $signed($urandom_range(131072)) - 65536;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t make_load(int idx);
        req_t r;
        r         = '0;
        r.command = CMD_LOAD;
        r.index_a = INDEX_W'(idx);
        r.index_b = INDEX_W'($urandom());
        r.index_c = INDEX_W'($urandom());
        r.pos_x   = rand_word();
        r.pos_y   = rand_word();
        r.pos_z   = rand_word();
        r.tex_u   = rand_word();
        r.tex_v   = rand_word();
        return r;
    endfunction

    function automatic req_t make_cmd(logic [1:0] cmd, int a, int b, int c);
        req_t r;
        r         = make_load(a);
        r.command = cmd;
        r.index_b = INDEX_W'(b);
        r.index_c = INDEX_W'(c);
        return r;
    endfunction

    task automatic load_vertex(int idx);
        bit fresh;
        fresh = !sb.loaded[idx];
        send_item(make_load(idx));
        if (fresh)
            tri_pool.push_back(idx);
    endtask

    // Drop valid and wait until every expected result has come.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random item: triangles over loaded vertices, loads, reads, and rarely a command 3.
    task automatic random_item();
        int   sel;
        int   a, b, c;
        req_t r;
        sel = $urandom_range(99);
        if (sel < 25 || tri_pool.size() < 3)
            load_vertex($urandom_range(DEPTH - 1));
        else if (sel < 65)
        begin
            a = tri_pool[$urandom_range(tri_pool.size() - 1)];
            b = tri_pool[$urandom_range(tri_pool.size() - 1)];
            c = tri_pool[$urandom_range(tri_pool.size() - 1)];
            send_item(make_cmd(CMD_TRI, a, b, c));
        end
        else if (sel < 95)
            send_item(make_cmd(CMD_READ, $urandom_range(DEPTH - 1), $urandom(), $urandom()));
        else
        begin
            r = make_cmd(CMD_NONE, $urandom(), $urandom(), $urandom());
            send_item(r);
        end
    endtask

    initial
    begin
        req_t r;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed: extremes of fields, every command, degenerate cases.
        load_vertex(0);
        load_vertex(DEPTH - 1);
        r = make_load(1);
        r.pos_x = 0; r.pos_y = 0; r.pos_z = 0; r.tex_u = 0; r.tex_v = 0;
        send_item(r); tri_pool.push_back(1);
        r = make_load(2);
        r.pos_x = 32'sh0001_0000; r.pos_y = 0; r.pos_z = 0;
        r.tex_u = 32'sh0001_0000; r.tex_v = 0;
        send_item(r); tri_pool.push_back(2);
        r = make_load(3);
        r.pos_x = 0; r.pos_y = 32'sh0001_0000; r.pos_z = DATA_MAX;
        r.tex_u = 0; r.tex_v = 32'sh0001_0000;
        send_item(r); tri_pool.push_back(3);
        r = make_load(4);
        r.pos_x = DATA_MIN; r.pos_y = DATA_MAX; r.pos_z = DATA_MIN;
        r.tex_u = DATA_MIN; r.tex_v = DATA_MAX;
        send_item(r); tri_pool.push_back(4);
        send_item(make_cmd(CMD_TRI, 1, 2, 3));
        send_item(make_cmd(CMD_TRI, 1, 2, 4));
        send_item(make_cmd(CMD_TRI, 4, 0, DEPTH - 1));
        // zero determinant: repeated corner
        send_item(make_cmd(CMD_TRI, 1, 1, 2));
        send_item(make_cmd(CMD_TRI, 2, 2, 2));
        send_item(make_cmd(CMD_READ, 1, 0, 0));
        send_item(make_cmd(CMD_READ, 2, DEPTH - 1, DEPTH - 1));
        send_item(make_cmd(CMD_READ, 3, 0, 0));
        send_item(make_cmd(CMD_READ, 4, 0, 0));
        send_item(make_cmd(CMD_READ, DEPTH - 1, 0, 0));
        send_item(make_cmd(CMD_NONE, DEPTH - 1, DEPTH - 1, DEPTH - 1));
        // reload clears the tangent sum
        load_vertex(1);
        send_item(make_cmd(CMD_READ, 1, 0, 0));

        // Random part; the part from one third to one half runs with no idling at all.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            idle_free = (n >= N_RANDOM / 3) && (n < N_RANDOM / 2);
            if (n == N_RANDOM / 4)
                hold_off_req = 1'b1;   // sender keeps going; block fills and stalls
            if (n == (2 * N_RANDOM) / 3)
                drain();               // pause until every result is in
            random_item();
        end

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
rtl/ttacc_pkg.sv
rtl/ttacc_mult.sv
rtl/ttacc_div.sv
rtl/triangle_tangent_accumulator_core.sv
bench/tb_triangle_tangent_accumulator_core.sv
